FILE: rtl/core/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared constants, types and helpers of the integer to ascii formatter:
// format codes, character codes, digit counts and prefix lookups.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int DATA_W          = 64;
    localparam int OP_W            = 2;
    localparam int CHAR_W          = 8;
    localparam int DEF_VALUE_BITS  = 64;
    localparam int PIDX_W          = 3;

    localparam logic [OP_W-1:0] OP_SDEC = 2'd0;
    localparam logic [OP_W-1:0] OP_UDEC = 2'd1;
    localparam logic [OP_W-1:0] OP_HEX  = 2'd2;
    localparam logic [OP_W-1:0] OP_ERR  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h45;
    localparam logic [CHAR_W-1:0] CH_R     = 8'h52;
    localparam logic [CHAR_W-1:0] CH_O     = 8'h4F;

    // start of one formatting job, sent to the emitter
    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] opcode;
        logic            neg;
    } emit_cmd_t;

    // decimal digits that cover any value of the given width
    function automatic int dec_digits(input int bits);
        return (bits * 1233) / 4096 + 1;
    endfunction

    function automatic int hex_digits(input int bits);
        return (bits + 3) / 4;
    endfunction

    function automatic logic [PIDX_W-1:0] prefix_len(input logic [OP_W-1:0] op,
                                                     input logic neg);
        logic [PIDX_W-1:0] len;
        unique case (op)
            OP_SDEC: len = neg ? 3'd1 : 3'd0;
            OP_UDEC: len = 3'd0;
            OP_HEX:  len = 3'd2;
            default: len = 3'd5;
        endcase
        return len;
    endfunction

    function automatic logic [CHAR_W-1:0] prefix_char(input logic [OP_W-1:0] op,
                                                      input logic [PIDX_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        unique case (op)
            OP_SDEC: ch = CH_MINUS;
            OP_UDEC: ch = CH_MINUS;
            OP_HEX:  ch = (idx == 3'd0) ? CH_ZERO : CH_X;
            default: begin
                unique case (idx)
                    3'd0:    ch = CH_E;
                    3'd3:    ch = CH_O;
                    default: ch = CH_R;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        return (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (CH_SEVEN + {4'd0, d});
    endfunction

endpackage

FILE: rtl/core/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a number as signed decimal, unsigned decimal or 0x-prefixed hex
// ascii text (ERROR for the error opcode), one character per output beat, last character marked.
// ----------------------------------------------------------------------------
// decimal: bit-serial bcd conversion of the value, then leading zero digits
//   dropped before the first character
// hex: leading zeros dropped, then the 0x prefix; the error word goes straight out
// one number at a time: no new input until the converter and the emitter are idle
// reset: aresetn synchronous active low, clears control and output valid
module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = i2a_pkg::DEF_VALUE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [i2a_pkg::DATA_W-1:0]    s_tdata,   // value
    input  logic [i2a_pkg::OP_W-1:0]      s_tuser,   // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [i2a_pkg::CHAR_W-1:0]    m_tdata,   // ascii_char
    output logic                          m_tlast
);

    localparam int NDIG = i2a_pkg::dec_digits(VALUE_BITS);
    localparam int HDIG = i2a_pkg::hex_digits(VALUE_BITS);
    localparam int DW   = NDIG * 4;
    localparam int HSH  = DW - HDIG * 4;

    logic [VALUE_BITS-1:0]      val;
    logic [VALUE_BITS-1:0]      mag;
    logic                       neg;
    logic [HDIG*4-1:0]          hexv;
    logic [DW-1:0]              hex_dig;
    logic                       accept;
    logic                       is_dec;
    logic                       conv_busy;
    logic                       conv_done;
    logic [DW-1:0]              bcd;
    logic                       emit_busy;
    logic [i2a_pkg::OP_W-1:0]   op_reg;
    logic                       neg_reg;
    i2a_pkg::emit_cmd_t         cmd;
    logic [DW-1:0]              emit_dig;

    assign val     = s_tdata[VALUE_BITS-1:0];
    assign neg     = (s_tuser == i2a_pkg::OP_SDEC) && val[VALUE_BITS-1];
    assign mag     = neg ? (~val + VALUE_BITS'(1)) : val;
    assign hexv    = (HDIG*4)'(val);
    assign hex_dig = DW'(hexv) << HSH;
    assign is_dec  = (s_tuser == i2a_pkg::OP_SDEC) || (s_tuser == i2a_pkg::OP_UDEC);

    assign s_tready = !conv_busy && !emit_busy;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_tuser;
            neg_reg <= neg;
        end
    end

    always_comb begin
        cmd.start  = conv_done || (accept && !is_dec);
        cmd.opcode = conv_done ? op_reg : s_tuser;
        cmd.neg    = conv_done ? neg_reg : 1'b0;
        emit_dig   = conv_done ? bcd : hex_dig;
    end

    i2a_bcd #(
        .VALUE_BITS (VALUE_BITS)
    ) u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && is_dec),
        .mag_in  (mag),
        .busy    (conv_busy),
        .done    (conv_done),
        .bcd_out (bcd)
    );

    i2a_emit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .digits   (emit_dig),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/core/i2a_bcd.sv
// ----------------------------------------------------------------------------
// i2a_bcd
// Shift-add binary to bcd converter: one value bit enters the digit
// shift register per cycle, each digit corrected by add-3 beforehand.
// ----------------------------------------------------------------------------
module i2a_bcd #(
    parameter int VALUE_BITS = i2a_pkg::DEF_VALUE_BITS
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            start,
    input  logic [VALUE_BITS-1:0]                           mag_in,
    output logic                                            busy,
    output logic                                            done,
    output logic [i2a_pkg::dec_digits(VALUE_BITS)*4-1:0]    bcd_out
);

    localparam int NDIG = i2a_pkg::dec_digits(VALUE_BITS);
    localparam int DW   = NDIG * 4;
    localparam int CW   = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [DW-1:0]         bcd_reg, bcd_next;
    logic [DW-1:0]         adj;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? (bcd_reg[4*i +: 4] + 4'd3)
                                                        : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            bcd_next = {adj[DW-2:0], mag_reg[VALUE_BITS-1]};
            mag_next = mag_reg << 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            mag_next  = mag_in;
            bcd_next  = '0;
            cnt_next  = CW'(VALUE_BITS);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign busy    = busy_reg | done_reg;
    assign done    = done_reg;
    assign bcd_out = bcd_reg;

endmodule

FILE: rtl/core/i2a_emit.sv
// ----------------------------------------------------------------------------
// i2a_emit
// Character emitter: drops leading zero digits one per cycle, then sends
// the prefix and the digits, most significant first, through an output
// register.
// ----------------------------------------------------------------------------
module i2a_emit #(
    parameter int VALUE_BITS = i2a_pkg::DEF_VALUE_BITS
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  i2a_pkg::emit_cmd_t                              cmd,
    input  logic [i2a_pkg::dec_digits(VALUE_BITS)*4-1:0]    digits,
    output logic                                            busy,
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    output logic [i2a_pkg::CHAR_W-1:0]                      m_tdata,
    output logic                                            m_tlast
);

    localparam int NDIG = i2a_pkg::dec_digits(VALUE_BITS);
    localparam int HDIG = i2a_pkg::hex_digits(VALUE_BITS);
    localparam int DW   = NDIG * 4;
    localparam int CW   = $clog2(NDIG + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_PFX  = 2'd2;
    localparam logic [1:0] ST_DIG  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [DW-1:0]                dig_reg, dig_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [i2a_pkg::PIDX_W-1:0]   pidx_reg, pidx_next;
    logic [i2a_pkg::OP_W-1:0]     op_reg, op_next;
    logic                         neg_reg, neg_next;
    logic                         valid_reg, valid_next;
    logic [i2a_pkg::CHAR_W-1:0]   data_reg, data_next;
    logic                         last_reg, last_next;
    logic                         out_free;
    logic                         load;
    logic [3:0]                   top_dig;
    logic [i2a_pkg::PIDX_W-1:0]   plen;

    assign out_free = !valid_reg || m_tready;
    assign top_dig  = dig_reg[DW-1 -: 4];
    assign plen     = i2a_pkg::prefix_len(op_reg, neg_reg);

    always_comb begin
        state_next = state_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        pidx_next  = pidx_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        load       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    op_next    = cmd.opcode;
                    neg_next   = cmd.neg;
                    dig_next   = digits;
                    cnt_next   = (cmd.opcode == i2a_pkg::OP_HEX) ? CW'(HDIG) : CW'(NDIG);
                    pidx_next  = '0;
                    state_next = (cmd.opcode == i2a_pkg::OP_ERR) ? ST_PFX : ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (cnt_reg > CW'(1) && top_dig == 4'd0) begin
                    dig_next = dig_reg << 4;
                    cnt_next = cnt_reg - CW'(1);
                end else begin
                    state_next = (plen != '0) ? ST_PFX : ST_DIG;
                end
            end
            ST_PFX: begin
                if (out_free) begin
                    load      = 1'b1;
                    data_next = i2a_pkg::prefix_char(op_reg, pidx_reg);
                    last_next = (op_reg == i2a_pkg::OP_ERR) &&
                                (pidx_reg == plen - i2a_pkg::PIDX_W'(1));
                    pidx_next = pidx_reg + i2a_pkg::PIDX_W'(1);
                    if (pidx_reg == plen - i2a_pkg::PIDX_W'(1)) begin
                        state_next = (op_reg == i2a_pkg::OP_ERR) ? ST_IDLE : ST_DIG;
                    end
                end
            end
            ST_DIG: begin
                if (out_free) begin
                    load      = 1'b1;
                    data_next = i2a_pkg::digit_char(top_dig);
                    last_next = (cnt_reg == CW'(1));
                    dig_next  = dig_reg << 4;
                    cnt_next  = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            pidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            pidx_reg  <= pidx_next;
        end
        dig_reg  <= dig_next;
        op_reg   <= op_next;
        neg_reg  <= neg_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: rtl/core/i2a_chk.sv
// ----------------------------------------------------------------------------
// i2a_chk
// Port-level checker of the integer to ascii formatter, bound to the top.
// ----------------------------------------------------------------------------
module i2a_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [i2a_pkg::DATA_W-1:0]    s_tdata,
    input logic [i2a_pkg::OP_W-1:0]      s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [i2a_pkg::CHAR_W-1:0]    m_tdata,
    input logic                          m_tlast
);

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // one number in flight
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // prefix characters never end the text
    a_pfx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata == i2a_pkg::CH_X || m_tdata == i2a_pkg::CH_MINUS) |-> !m_tlast)
        else $error("prefix marked last");

    // reset empties the output
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind integer_to_ascii_formatter i2a_chk u_i2a_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
